FILE: src/hkv_pkg.sv
// Shared types, codes and byte-mask helpers for the hash key-value store.
// No dependencies.
package hkv_pkg;

   // request codes
   localparam logic [1:0] OP_STORE    = 2'd0;
   localparam logic [1:0] OP_FETCH    = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_INVALID = 2'd3;

   // slot marks
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   // one classified request word, as it travels from front to back
   typedef struct packed {
      logic        invalid;
      logic [1:0]  op;
      logic [63:0] key_lo;
      logic [47:0] key_hi;
      logic [63:0] val_lo;
      logic [47:0] val_hi;
   } item_type;

   // one slot as held in the table memory
   typedef struct packed {
      logic [1:0]  mark;
      logic [63:0] key_lo;
      logic [47:0] key_hi;
      logic [63:0] val_lo;
      logic [47:0] val_hi;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);
   localparam int ITEM_W = $bits(item_type);

   // keep bytes 0..7 below length n
   function automatic logic [63:0] mask_lo(input logic [3:0] n);
      logic [63:0] m;
      for (int i = 0; i < 8; i++) begin
         m[8*i +: 8] = (n > 4'(i)) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // keep bytes 8..13 below length n
   function automatic logic [47:0] mask_hi(input logic [3:0] n);
      logic [47:0] m;
      for (int i = 0; i < 6; i++) begin
         m[8*i +: 8] = (n > 4'(i + 8)) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

FILE: src/hkv_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/hkv_front.sv
// Front end: accepts a request, checks it, masks key/value bytes, hashes the
// key and reduces the hash to a bucket number. Depends on hkv_pkg.
module hkv_front #(
   parameter int BUCKETS   = 1024,
   parameter int MAX_CHARS = 14,
   parameter int BW        = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             hold,
   input  logic [1:0]       req_type,
   input  logic [63:0]      req_key_low,
   input  logic [47:0]      req_key_high,
   input  logic [3:0]       req_key_len,
   input  logic [63:0]      req_value_low,
   input  logic [47:0]      req_value_high,
   input  logic [3:0]       req_value_len,
   output logic             idle,
   output logic             push_valid,
   input  logic             push_ready,
   output hkv_pkg::item_type push_item,
   output logic [BW-1:0]    push_bucket
);
   import hkv_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   item_type    item_ff, item_in;
   logic [3:0]  len_ff, len_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] hash_ff, hash_in;
   logic [BW-1:0] rem_ff, rem_in;

   logic         bad;
   logic [111:0] key_cat;
   logic [7:0]   cur_char;

   // four restoring steps of hash mod BUCKETS, top bits first
   function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r,
                                              input logic [3:0] bits);
      logic [BW:0]   t;
      logic [BW-1:0] acc;
      acc = r;
      for (int j = 3; j >= 0; j--) begin
         t = {acc, bits[j]};
         if (t >= (BW+1)'(BUCKETS)) begin
            t = t - (BW+1)'(BUCKETS);
         end
         acc = t[BW-1:0];
      end
      return acc;
   endfunction

   // request check
   assign bad = (req_type == OP_RESERVED) || (req_key_len == 4'd0) ||
                (req_key_len > 4'(MAX_CHARS)) ||
                ((req_type == OP_STORE) &&
                 ((req_value_len == 4'd0) || (req_value_len > 4'(MAX_CHARS))));

   assign key_cat  = {item_ff.key_hi, item_ff.key_lo};
   assign cur_char = 8'(key_cat >> {cnt_ff, 3'b000});

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      hash_in  = hash_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start && !hold) begin
               item_in.invalid = bad;
               item_in.op      = req_type;
               item_in.key_lo  = req_key_low & mask_lo(req_key_len);
               item_in.key_hi  = req_key_high & mask_hi(req_key_len);
               item_in.val_lo  = req_value_low & mask_lo(req_value_len);
               item_in.val_hi  = req_value_high & mask_hi(req_value_len);
               len_in   = req_key_len;
               cnt_in   = 4'd0;
               hash_in  = 64'd0;
               rem_in   = '0;
               state_in = bad ? F_PUSH : F_HASH;
            end
         end
         F_HASH: begin
            // h = h*31 + c, one character a cycle
            hash_in = (hash_ff << 5) - hash_ff + 64'(cur_char);
            if (cnt_ff == len_ff - 4'd1) begin
               cnt_in   = 4'd0;
               state_in = F_MOD;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         F_MOD: begin
            rem_in  = mod_step(rem_ff, hash_ff[63:60]);
            hash_in = hash_ff << 4;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      len_ff  <= len_in;
      cnt_ff  <= cnt_in;
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
   end

   assign idle        = (state_ff == F_IDLE);
   assign push_valid  = (state_ff == F_PUSH);
   assign push_item   = item_ff;
   assign push_bucket = rem_ff;
endmodule

FILE: src/hkv_queue.sv
// Two-entry queue between front and back ends. No dependencies.
module hkv_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

FILE: src/hkv_back.sv
// Back end: clears the slot table after reset, then probes buckets for each
// valid queued request and writes the result strobe. Depends on hkv_pkg, hkv_ram.
module hkv_back #(
   parameter int BUCKETS = 1024,
   parameter int SLOTS   = 8,
   parameter int BW      = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  hkv_pkg::item_type pop_item,
   input  logic [BW-1:0]     pop_bucket,
   output logic              clearing,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [63:0]       rsp_found_low,
   output logic [47:0]       rsp_found_high
);
   import hkv_pkg::*;

   localparam int TOTAL = BUCKETS * SLOTS;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [4:0] {
      B_CLEAR = 5'b00001,
      B_IDLE  = 5'b00010,
      B_START = 5'b00100,
      B_READ  = 5'b01000,
      B_EVAL  = 5'b10000
   } bstate_type;

   bstate_type    state_ff, state_in;
   item_type      item_ff, item_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [BW-1:0] bucket_ff, bucket_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          saw_empty_ff, saw_empty_in;
   logic          have_free_ff, have_free_in;
   logic [AW-1:0] free_at_ff, free_at_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [63:0]   found_lo_ff, found_lo_in;
   logic [47:0]   found_hi_ff, found_hi_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr;
   slot_type      wr_data, rd_data;

   logic hit, empty_n, free_n, last_slot;
   logic [AW-1:0] free_at_n;

   hkv_ram #(.WIDTH(SLOT_W), .DEPTH(TOTAL)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // slot classification
   assign hit = (rd_data.mark == MARK_USED) && (rd_data.key_lo == item_ff.key_lo) &&
                (rd_data.key_hi == item_ff.key_hi);
   assign empty_n   = saw_empty_ff || (rd_data.mark == MARK_EMPTY);
   assign free_n    = have_free_ff || (rd_data.mark != MARK_USED);
   assign free_at_n = (have_free_ff || (rd_data.mark == MARK_USED)) ? free_at_ff : addr_ff;
   assign last_slot = (slot_ff == SW'(SLOTS - 1));

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      bucket_in    = bucket_ff;
      slot_in      = slot_ff;
      saw_empty_in = saw_empty_ff;
      have_free_in = have_free_ff;
      free_at_in   = free_at_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      found_lo_in  = found_lo_ff;
      found_hi_in  = found_hi_ff;
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(TOTAL - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               item_in   = pop_item;
               bucket_in = pop_bucket;
               state_in  = B_START;
            end
         end
         B_START: begin
            found_lo_in = 64'd0;
            found_hi_in = 48'd0;
            if (item_ff.invalid) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_INVALID;
               state_in     = B_IDLE;
            end else begin
               addr_in      = AW'(bucket_ff * SLOTS);
               slot_in      = '0;
               saw_empty_in = 1'b0;
               have_free_in = 1'b0;
               state_in     = B_READ;
            end
         end
         B_READ: begin
            rd_en    = 1'b1;
            state_in = B_EVAL;
         end
         B_EVAL: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               state_in     = B_IDLE;
               unique case (item_ff.op)
                  OP_STORE: begin
                     wr_en   = 1'b1;
                     wr_data = {MARK_USED, item_ff.key_lo, item_ff.key_hi,
                                item_ff.val_lo, item_ff.val_hi};
                  end
                  OP_FETCH: begin
                     found_lo_in = rd_data.val_lo;
                     found_hi_in = rd_data.val_hi;
                  end
                  default: begin
                     wr_en   = 1'b1;
                     wr_data = {MARK_TOMB, rd_data.key_lo, rd_data.key_hi,
                                rd_data.val_lo, rd_data.val_hi};
                  end
               endcase
            end else if (last_slot && (empty_n || bucket_ff == BW'(BUCKETS - 1))) begin
               // end of chain
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
               if (item_ff.op == OP_STORE) begin
                  if (free_n) begin
                     wr_en     = 1'b1;
                     wr_addr   = free_at_n;
                     wr_data   = {MARK_USED, item_ff.key_lo, item_ff.key_hi,
                                  item_ff.val_lo, item_ff.val_hi};
                     status_in = ST_OK;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else begin
                  status_in = ST_MISS;
               end
            end else begin
               addr_in      = addr_ff + AW'(1);
               have_free_in = free_n;
               free_at_in   = free_at_n;
               if (last_slot) begin
                  bucket_in    = bucket_ff + BW'(1);
                  slot_in      = '0;
                  saw_empty_in = 1'b0;
               end else begin
                  slot_in      = slot_ff + SW'(1);
                  saw_empty_in = empty_n;
               end
               state_in = B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      bucket_ff    <= bucket_in;
      slot_ff      <= slot_in;
      saw_empty_ff <= saw_empty_in;
      have_free_ff <= have_free_in;
      free_at_ff   <= free_at_in;
      status_ff    <= status_in;
      found_lo_ff  <= found_lo_in;
      found_hi_ff  <= found_hi_in;
   end

   assign pop_ready      = (state_ff == B_IDLE);
   assign clearing       = (state_ff == B_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_found_low  = found_lo_ff;
   assign rsp_found_high = found_hi_ff;
endmodule

FILE: src/bucketed_hash_key_value_store.sv
// Top level of the bucketed hash key-value store.
// Depends on hkv_pkg, hkv_front, hkv_queue, hkv_back, hkv_ram.
//
// A word is taken when start is high and busy is low; every word gives one
// response strobe (rsp_valid, one cycle, cannot be held off). After reset all
// BUCKETS*SLOTS slots (8192 by default) are swept clear with busy high. The
// front end then hashes the key one character at a time, reduces the hash
// modulo BUCKETS four bits a step, and hands the word off; a two-word queue
// lets it take the next word while the back end works. The back end reads,
// then compares, each probed slot on the table memory port, one bucket of 8
// slots after another until the chain ends. Invalid requests skip the probe
// and answer in order with the rest.
module bucketed_hash_key_value_store #(
   parameter int BUCKETS   = 1024,
   parameter int SLOTS     = 8,
   parameter int MAX_CHARS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_low,
   input  logic [47:0] req_key_high,
   input  logic [3:0]  req_key_len,
   input  logic [63:0] req_value_low,
   input  logic [47:0] req_value_high,
   input  logic [3:0]  req_value_len,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_found_low,
   output logic [47:0] rsp_found_high
);
   import hkv_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   logic          front_idle, clearing;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   item_type      push_item, pop_item;
   logic [BW-1:0] push_bucket, pop_bucket;

   hkv_front #(.BUCKETS(BUCKETS), .MAX_CHARS(MAX_CHARS), .BW(BW)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .hold           (clearing),
      .req_type       (req_type),
      .req_key_low    (req_key_low),
      .req_key_high   (req_key_high),
      .req_key_len    (req_key_len),
      .req_value_low  (req_value_low),
      .req_value_high (req_value_high),
      .req_value_len  (req_value_len),
      .idle           (front_idle),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item),
      .push_bucket    (push_bucket)
   );

   hkv_queue #(.WIDTH(ITEM_W + BW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_bucket, push_item}),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  ({pop_bucket, pop_item})
   );

   hkv_back #(.BUCKETS(BUCKETS), .SLOTS(SLOTS), .BW(BW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .pop_bucket     (pop_bucket),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_found_low  (rsp_found_low),
      .rsp_found_high (rsp_found_high)
   );

   assign busy = !front_idle || clearing;
endmodule

FILE: src/hkv_checker.sv
// Port-level checks for the hash key-value store, bound to the top level.
// Depends on hkv_pkg and bucketed_hash_key_value_store.
module hkv_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_found_low,
   input logic [47:0] rsp_found_high
);
   import hkv_pkg::*;

   // responses are single-cycle strobes separated by a gap
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

   // only an OK response may carry found data
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_found_low == 64'd0 &&
                                             rsp_found_high == 48'd0))
      else $error("data on a failed response");

   // table sweep holds off words right after reset
   a_clear_busy: assert property (@(posedge clock)
      $past(reset) |-> busy || reset)
      else $error("not busy after reset");

   // no response during the table sweep right after reset
   a_clear_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
endmodule

bind bucketed_hash_key_value_store hkv_checker u_hkv_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_found_low  (rsp_found_low),
   .rsp_found_high (rsp_found_high)
);

FILE: test/bucketed_hash_key_value_store_test.sv
// Testbench for bucketed_hash_key_value_store: directed table, then random words.
// Depends on hkv_pkg and the store RTL. Responses are checked against a local table model.
`timescale 1ns / 1ps

module bucketed_hash_key_value_store_test;
   import hkv_pkg::*;

   localparam int NBUCKETS   = 1024;
   localparam int NSLOTS     = 8;
   localparam int NTOTAL     = NBUCKETS * NSLOTS;
   localparam int NCHARS     = 14;
   localparam int RANDOM_WORDS = 1030;
   localparam int CALM_TAIL  = 120;
   localparam int STALL_LIMIT = 40000;
   localparam int POOL_KEYS  = 48;

   typedef struct {
      logic [1:0]  status;
      logic [63:0] found_low;
      logic [47:0] found_high;
   } answer_t;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] klo;
      logic [47:0] khi;
      logic [3:0]  klen;
      logic [63:0] vlo;
      logic [47:0] vhi;
      logic [3:0]  vlen;
      bit          typed;
      answer_t     ans;
   } word_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [63:0] req_key_low = '0;
   logic [47:0] req_key_high = '0;
   logic [3:0]  req_key_len = '0;
   logic [63:0] req_value_low = '0;
   logic [47:0] req_value_high = '0;
   logic [3:0]  req_value_len = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_found_low;
   logic [47:0] rsp_found_high;

   bucketed_hash_key_value_store dut (.*);

   // table model state
   logic [1:0]  tbl_mark [NTOTAL];
   logic [63:0] tbl_klo  [NTOTAL];
   logic [47:0] tbl_khi  [NTOTAL];
   logic [63:0] tbl_vlo  [NTOTAL];
   logic [47:0] tbl_vhi  [NTOTAL];

   answer_t pending_answers[$];
   int      mismatches = 0;
   int      words_sent = 0;
   int      answers_seen = 0;
   int      full_seen = 0;
   int      hits_seen = 0;
   bit      idle_ok = 1;

   word_t   rows[$];
   logic [63:0] pool_lo  [POOL_KEYS];
   logic [47:0] pool_hi  [POOL_KEYS];
   logic [3:0]  pool_len [POOL_KEYS];

   initial begin
      forever #2 clock = ~clock;
   end

   // byte masks by length
   function automatic logic [63:0] lo_bytes(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) if (n > i) m[8*i +: 8] = 8'hFF;
      return m;
   endfunction

   function automatic logic [47:0] hi_bytes(input logic [3:0] n);
      logic [47:0] m;
      m = '0;
      for (int i = 0; i < 6; i++) if (n > i + 8) m[8*i +: 8] = 8'hFF;
      return m;
   endfunction

   function automatic int bucket_of(input logic [63:0] klo, input logic [47:0] khi,
                                    input logic [3:0] klen);
      logic [63:0] h;
      logic [7:0]  c;
      h = '0;
      for (int i = 0; i < klen; i++) begin
         c = (i < 8) ? klo[8*i +: 8] : khi[8*(i-8) +: 8];
         h = h * 64'd31 + {56'd0, c};
      end
      return int'(h % NBUCKETS);
   endfunction

   // apply one word to the table model and return its answer
   function automatic answer_t table_apply(input word_t w);
      answer_t a;
      logic [63:0] klo, vlo;
      logic [47:0] khi, vhi;
      bit have_free, saw_empty;
      int free_at, idx;
      a.status = ST_OK; a.found_low = '0; a.found_high = '0;
      if (w.op == 2'd3 || w.klen == 0 || w.klen > NCHARS ||
          (w.op == OP_STORE && (w.vlen == 0 || w.vlen > NCHARS))) begin
         a.status = ST_INVALID;
         return a;
      end
      klo = w.klo & lo_bytes(w.klen); khi = w.khi & hi_bytes(w.klen);
      vlo = w.vlo & lo_bytes(w.vlen); vhi = w.vhi & hi_bytes(w.vlen);
      have_free = 0; free_at = 0;
      for (int b = bucket_of(klo, khi, w.klen); b < NBUCKETS; b++) begin
         saw_empty = 0;
         for (int s = 0; s < NSLOTS; s++) begin
            idx = b * NSLOTS + s;
            if (tbl_mark[idx] == MARK_USED) begin
               if (tbl_klo[idx] == klo && tbl_khi[idx] == khi) begin
                  if (w.op == OP_STORE) begin
                     tbl_vlo[idx] = vlo; tbl_vhi[idx] = vhi;
                  end else if (w.op == OP_FETCH) begin
                     a.found_low = tbl_vlo[idx]; a.found_high = tbl_vhi[idx];
                  end else begin
                     tbl_mark[idx] = MARK_TOMB;
                  end
                  return a;
               end
            end else begin
               if (!have_free) begin have_free = 1; free_at = idx; end
               if (tbl_mark[idx] == MARK_EMPTY) saw_empty = 1;
            end
         end
         if (saw_empty) break;
      end
      if (w.op != OP_STORE) begin
         a.status = ST_MISS;
      end else if (!have_free) begin
         a.status = ST_FULL;
      end else begin
         tbl_mark[free_at] = MARK_USED;
         tbl_klo[free_at] = klo; tbl_khi[free_at] = khi;
         tbl_vlo[free_at] = vlo; tbl_vhi[free_at] = vhi;
      end
      return a;
   endfunction

   // short printable key that lands in the given bucket
   task automatic key_for_bucket(input int target, output logic [63:0] klo,
                                 output logic [47:0] khi, output logic [3:0] klen);
      do begin
         klen = 4'($urandom_range(2, 4));
         klo = '0; khi = '0;
         for (int i = 0; i < klen; i++) klo[8*i +: 8] = 8'($urandom_range(33, 126));
      end while (bucket_of(klo, khi, klen) != target);
   endtask

   function automatic word_t mk(input logic [1:0] op, input logic [63:0] klo,
                                input logic [47:0] khi, input logic [3:0] klen,
                                input logic [63:0] vlo, input logic [47:0] vhi,
                                input logic [3:0] vlen);
      word_t w;
      w.op = op; w.klo = klo; w.khi = khi; w.klen = klen;
      w.vlo = vlo; w.vhi = vhi; w.vlen = vlen; w.typed = 0;
      w.ans.status = ST_OK; w.ans.found_low = '0; w.ans.found_high = '0;
      return w;
   endfunction

   function automatic word_t typed(input word_t w, input logic [1:0] st,
                                   input logic [63:0] flo, input logic [47:0] fhi);
      w.typed = 1; w.ans.status = st; w.ans.found_low = flo; w.ans.found_high = fhi;
      return w;
   endfunction

   // present one word, with an optional idle burst ahead of it
   task automatic send_word(input word_t w);
      answer_t a;
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_type <= w.op; req_key_low <= w.klo; req_key_high <= w.khi;
      req_key_len <= w.klen; req_value_low <= w.vlo; req_value_high <= w.vhi;
      req_value_len <= w.vlen; start <= 1'b1;
      do @(posedge clock); while (busy);
      a = table_apply(w);
      pending_answers.push_back(w.typed ? w.ans : a);
      words_sent++;
   endtask

   // response checker
   always @(posedge clock) begin
      answer_t e;
      if (!reset && rsp_valid) begin
         answers_seen++;
         if (rsp_status == ST_FULL) full_seen++;
         if (rsp_status == ST_OK && rsp_found_low != 0) hits_seen++;
         if (pending_answers.size() == 0) begin
            $error("response with nothing pending: status %0d", rsp_status);
            mismatches++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               mismatches++;
            end
            if (rsp_found_low !== e.found_low) begin
               $error("found_low: expected %h, got %h", e.found_low, rsp_found_low);
               mismatches++;
            end
            if (rsp_found_high !== e.found_high) begin
               $error("found_high: expected %h, got %h", e.found_high, rsp_found_high);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      word_t w;
      logic [63:0] klo, vlo;
      logic [47:0] khi, vhi;
      logic [3:0]  klen;
      int pick, roll;
      for (int i = 0; i < NTOTAL; i++) begin
         tbl_mark[i] = MARK_EMPTY;
         tbl_klo[i] = '0; tbl_khi[i] = '0; tbl_vlo[i] = '0; tbl_vhi[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      rows.push_back(typed(mk(OP_FETCH, 64'h61, 0, 1, 0, 0, 0), ST_MISS, 0, 0));
      rows.push_back(typed(mk(OP_DELETE, 64'h61, 0, 1, 0, 0, 0), ST_MISS, 0, 0));
      rows.push_back(typed(mk(2'd3, 64'h61, 0, 1, 64'h62, 0, 1), ST_INVALID, 0, 0));
      rows.push_back(typed(mk(OP_FETCH, 64'h61, 0, 0, 0, 0, 0), ST_INVALID, 0, 0));
      rows.push_back(typed(mk(OP_STORE, '1, '1, 15, 64'h62, 0, 1), ST_INVALID, 0, 0));
      rows.push_back(typed(mk(OP_STORE, 64'h61, 0, 1, 64'h62, 0, 0), ST_INVALID, 0, 0));
      rows.push_back(typed(mk(OP_STORE, 64'h61, 0, 1, '1, '1, 15), ST_INVALID, 0, 0));
      rows.push_back(typed(mk(OP_STORE, '1, '1, 14, '1, '1, 14), ST_OK, 0, 0));
      rows.push_back(typed(mk(OP_FETCH, '1, '1, 14, 0, 0, 15), ST_OK, '1, '1));
      rows.push_back(typed(mk(OP_STORE, 64'hFFFF_FF00_0000_0041, '1, 1, '1, '1, 1),
                           ST_OK, 0, 0));
      rows.push_back(mk(OP_FETCH, 64'h41, 0, 1, 0, 0, 0));
      rows.push_back(mk(OP_STORE, 64'h41, 48'h1234, 1, 64'h0102, 0, 2));
      rows.push_back(mk(OP_FETCH, 64'h41, 0, 1, 0, 0, 0));
      rows.push_back(typed(mk(OP_DELETE, '1, '1, 14, 0, 0, 0), ST_OK, 0, 0));
      rows.push_back(typed(mk(OP_FETCH, '1, '1, 14, 0, 0, 0), ST_MISS, 0, 0));
      rows.push_back(mk(OP_STORE, '1, '1, 14, 64'h55, 0, 8));
      rows.push_back(mk(OP_FETCH, '1, '1, 14, 0, 0, 0));
      // fill the last bucket, then one more store finds the table full
      for (int i = 0; i < NSLOTS + 1; i++) begin
         key_for_bucket(NBUCKETS - 1, klo, khi, klen);
         rows.push_back(mk(OP_STORE, klo, khi, klen, 64'(i + 1), 0, 1));
      end
      foreach (rows[i]) send_word(rows[i]);

      // key pool: most keys crowd the top buckets so chains overflow and fill
      for (int i = 0; i < POOL_KEYS; i++) begin
         if (i < 32) begin
            key_for_bucket(NBUCKETS - 1 - $urandom_range(0, 5), klo, khi, klen);
         end else begin
            klen = 4'($urandom_range(1, 14));
            klo = {$urandom, $urandom}; khi = 48'({$urandom, $urandom});
         end
         pool_lo[i] = klo; pool_hi[i] = khi; pool_len[i] = klen;
      end

      // random words
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         idle_ok = (n < RANDOM_WORDS - CALM_TAIL);
         roll = $urandom_range(0, 99);
         vlo = {$urandom, $urandom}; vhi = 48'({$urandom, $urandom});
         if (roll < 85) begin
            pick = $urandom_range(0, POOL_KEYS - 1);
            klen = pool_len[pick];
            // garbage above the key length must be ignored
            klo = (pool_lo[pick] & lo_bytes(klen)) | ({$urandom, $urandom} & ~lo_bytes(klen));
            khi = (pool_hi[pick] & hi_bytes(klen))
                | (48'({$urandom, $urandom}) & ~hi_bytes(klen));
            roll = $urandom_range(0, 99);
            w = mk(roll < 45 ? OP_STORE : roll < 80 ? OP_FETCH : OP_DELETE,
                   klo, khi, klen, vlo, vhi, 4'($urandom_range(1, 14)));
            if (w.op != OP_STORE) w.vlen = 4'($urandom_range(0, 15));
         end else if (roll < 95) begin
            w = mk(2'($urandom_range(0, 2)), {$urandom, $urandom},
                   48'({$urandom, $urandom}), 4'($urandom_range(1, 14)),
                   vlo, vhi, 4'($urandom_range(1, 14)));
         end else begin
            w = mk(2'($urandom_range(0, 3)), {$urandom, $urandom},
                   48'({$urandom, $urandom}), 4'($urandom_range(0, 15)),
                   vlo, vhi, 4'($urandom_range(0, 15)));
         end
         send_word(w);
      end
      start <= 1'b0;

      // drain, then let any late strobe show up
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d words, %0d responses, %0d fetch hits, %0d table-full answers",
               words_sent, answers_seen, hits_seen, full_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
